>>> rtl/core/gwf_pkg.sv
// ----------------------------------------------------------------------------
// gwf_pkg: shared types and constants of the grid wall follower
// Field widths, operation and outcome codes, headings, controller states and
// the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package gwf_pkg;

   // payload field widths
   localparam int ROW_W   = 4;
   localparam int COL_W   = 5;
   localparam int OP_W    = 2;
   localparam int OUT_W   = 2;
   localparam int CSR_D_W = 5;

   // default grid size
   localparam int DEF_GRID_ROWS = 16;
   localparam int DEF_GRID_COLS = 32;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE   = 2'd0,
      OP_STEP    = 2'd1,
      OP_RESTART = 2'd2,
      OP_NOP     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      DIR_DOWN  = 2'd0,
      DIR_RIGHT = 2'd1,
      DIR_UP    = 2'd2,
      DIR_LEFT  = 2'd3
   } dir_type;

   typedef enum logic [OUT_W-1:0] {
      OUT_MOVING = 2'd0,
      OUT_EXITED = 2'd1,
      OUT_BACK   = 2'd2,
      OUT_STUCK  = 2'd3
   } outcome_type;

   typedef enum logic {
      CSR_START_ROW = 1'b0,
      CSR_START_COL = 1'b1
   } csr_idx_type;

   // map memory read address select
   typedef enum logic [1:0] {
      RD_ITEM = 2'd0,
      RD_UP   = 2'd1,
      RD_MID  = 2'd2,
      RD_DN   = 2'd3
   } rd_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WR_READ,
      ST_WR_WRITE,
      ST_RD_UP,
      ST_RD_MID,
      ST_RD_DN,
      ST_CAP_DN,
      ST_MOVE,
      ST_RESTART,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic       latch;
      rd_sel_type rd_sel;
      logic       cap_up;
      logic       cap_mid;
      logic       cap_dn;
      logic       wr_row;
      logic       move;
      logic       restart;
      logic       load_rsp;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   wr_ok;
      logic   finished;
      logic   rsp_free;
   } status_type;

   // heading taken after a move in the given direction
   function automatic dir_type turn_after(dir_type moved);
      dir_type nxt;
      case (moved)
         DIR_DOWN:  nxt = DIR_LEFT;
         DIR_RIGHT: nxt = DIR_DOWN;
         DIR_UP:    nxt = DIR_RIGHT;
         DIR_LEFT:  nxt = DIR_UP;
         default:   nxt = DIR_RIGHT;
      endcase
      return nxt;
   endfunction

endpackage

>>> rtl/core/gwf_if.sv
// ----------------------------------------------------------------------------
// gwf_if: channel interfaces of the grid wall follower
// Request, response and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface gwf_req_if import gwf_pkg::*; ();
   logic               valid;
   logic               ready;
   op_type             op;
   logic [ROW_W-1:0]   cell_row;
   logic [COL_W-1:0]   cell_col;
   logic               cell_open;

   modport source (output valid, op, cell_row, cell_col, cell_open, input ready);
   modport sink   (input valid, op, cell_row, cell_col, cell_open, output ready);
endinterface

interface gwf_rsp_if import gwf_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [ROW_W-1:0]   pos_row;
   logic [COL_W-1:0]   pos_col;
   outcome_type        outcome;

   modport source (output valid, pos_row, pos_col, outcome, input ready);
   modport sink   (input valid, pos_row, pos_col, outcome, output ready);
endinterface

interface gwf_csr_if import gwf_pkg::*; ();
   logic               valid;
   logic               ready;
   csr_idx_type        index;
   logic [CSR_D_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/gwf_ram.sv
// ----------------------------------------------------------------------------
// gwf_ram: generic single write, single read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gwf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/gwf_ctrl.sv
// ----------------------------------------------------------------------------
// gwf_ctrl: sequencer of the grid wall follower
// Takes one request at a time and steps the datapath through the map reads,
// the move and the response hand-off.
// ----------------------------------------------------------------------------
module gwf_ctrl import gwf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.rd_sel = RD_ITEM;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               case (status.op)
                  OP_WRITE:   state_in = status.wr_ok ? ST_WR_READ : ST_IDLE;
                  OP_STEP:    state_in = status.finished ? ST_EMIT : ST_RD_UP;
                  OP_RESTART: state_in = ST_RESTART;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_WR_READ: begin
            cmd.rd_sel = RD_ITEM;
            state_in   = ST_WR_WRITE;
         end
         ST_WR_WRITE: begin
            cmd.wr_row = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_RD_UP: begin
            cmd.rd_sel = RD_UP;
            state_in   = ST_RD_MID;
         end
         ST_RD_MID: begin
            cmd.rd_sel = RD_MID;
            cmd.cap_up = 1'b1;
            state_in   = ST_RD_DN;
         end
         ST_RD_DN: begin
            cmd.rd_sel  = RD_DN;
            cmd.cap_mid = 1'b1;
            state_in    = ST_CAP_DN;
         end
         ST_CAP_DN: begin
            cmd.cap_dn = 1'b1;
            state_in   = ST_MOVE;
         end
         ST_MOVE: begin
            cmd.move = 1'b1;
            state_in = ST_EMIT;
         end
         ST_RESTART: begin
            cmd.restart = 1'b1;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/core/gwf_dp.sv
// ----------------------------------------------------------------------------
// gwf_dp: datapath of the grid wall follower
// Map memory with per-row valid bits, walker position and heading, start
// registers, the neighbor search and the response register.
// ----------------------------------------------------------------------------
module gwf_dp import gwf_pkg::*; #(
   parameter int GRID_ROWS = DEF_GRID_ROWS,
   parameter int GRID_COLS = DEF_GRID_COLS
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   // request payload
   input  op_type             req_op,
   input  logic [ROW_W-1:0]   req_cell_row,
   input  logic [COL_W-1:0]   req_cell_col,
   input  logic               req_cell_open,
   // register writes
   input  logic               csr_write,
   input  csr_idx_type        csr_index,
   input  logic [CSR_D_W-1:0] csr_data,
   // response
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [ROW_W-1:0]   rsp_pos_row,
   output logic [COL_W-1:0]   rsp_pos_col,
   output outcome_type        rsp_outcome
);

   localparam int RW  = $clog2(GRID_ROWS);
   localparam int CW  = $clog2(GRID_COLS);
   localparam int RXW = (RW > ROW_W) ? RW : ROW_W;
   localparam int CXW = (CW > COL_W) ? CW : COL_W;
   localparam logic [RW-1:0] LAST_ROW = RW'(GRID_ROWS - 1);
   localparam logic [CW-1:0] LAST_COL = CW'(GRID_COLS - 1);

   // configuration
   logic [ROW_W-1:0] start_row_ff;
   logic [COL_W-1:0] start_col_ff;
   logic [RW-1:0]    start_r;
   logic [CW-1:0]    start_c;

   // latched request
   logic [RW-1:0] item_row_ff;
   logic [CW-1:0] item_col_ff;
   logic          item_open_ff;

   // walker state
   logic [RW-1:0] cur_row_ff;
   logic [CW-1:0] cur_col_ff;
   dir_type       heading_ff;
   logic          finished_ff;
   outcome_type   outcome_ff;

   // map memory access
   logic [GRID_ROWS-1:0] row_valid_ff;
   logic                 rd_valid_ff;
   logic [RW-1:0]        rd_addr;
   logic [GRID_COLS-1:0] rd_data;
   logic [GRID_COLS-1:0] row_rd;
   logic [GRID_COLS-1:0] wr_data;
   logic [GRID_COLS-1:0] row_up_ff;
   logic [GRID_COLS-1:0] row_mid_ff;
   logic [GRID_COLS-1:0] row_dn_ff;

   // move search
   logic [3:0]    dir_open;
   logic          found;
   dir_type       mv_dir;
   logic [RW-1:0] nxt_row;
   logic [CW-1:0] nxt_col;
   logic [CW-1:0] col_p1;
   logic [CW-1:0] col_m1;
   logic          at_start;
   logic          at_edge;
   outcome_type   mv_outcome;

   // response
   logic               rsp_valid_ff;
   logic [ROW_W-1:0]   rsp_pos_row_ff;
   logic [COL_W-1:0]   rsp_pos_col_ff;
   outcome_type        rsp_outcome_ff;
   logic [RXW-1:0]     cur_row_x;
   logic [CXW-1:0]     cur_col_x;

   // start registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_row_ff <= '0;
         start_col_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_START_ROW: start_row_ff <= csr_data[ROW_W-1:0];
            CSR_START_COL: start_col_ff <= csr_data[COL_W-1:0];
            default: ;
         endcase
      end
   end

   // start cell saturates into the grid
   assign start_r = (int'(start_row_ff) < GRID_ROWS) ? RW'(start_row_ff) : LAST_ROW;
   assign start_c = (int'(start_col_ff) < GRID_COLS) ? CW'(start_col_ff) : LAST_COL;

   // status back to the sequencer
   assign status.op       = req_op;
   assign status.wr_ok    = (int'(req_cell_row) < GRID_ROWS) &&
                            (int'(req_cell_col) < GRID_COLS);
   assign status.finished = finished_ff;
   assign status.rsp_free = !rsp_valid_ff || rsp_ready;

   // request latch
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         item_row_ff  <= RW'(req_cell_row);
         item_col_ff  <= CW'(req_cell_col);
         item_open_ff <= req_cell_open;
      end
   end

   // map read address, clamped at the grid border
   always_comb begin
      case (cmd.rd_sel)
         RD_ITEM: rd_addr = item_row_ff;
         RD_UP:   rd_addr = (cur_row_ff == '0) ? cur_row_ff : cur_row_ff - 1'b1;
         RD_MID:  rd_addr = cur_row_ff;
         RD_DN:   rd_addr = (cur_row_ff == LAST_ROW) ? cur_row_ff : cur_row_ff + 1'b1;
         default: rd_addr = cur_row_ff;
      endcase
   end

   gwf_ram #(
      .WIDTH (GRID_COLS),
      .DEPTH (GRID_ROWS)
   ) u_map (
      .clock   (clock),
      .wr_en   (cmd.wr_row),
      .wr_addr (item_row_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // rows never written read as all wall
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (cmd.wr_row) begin
         row_valid_ff[item_row_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rd_valid_ff <= row_valid_ff[rd_addr];
   end

   assign row_rd = rd_valid_ff ? rd_data : '0;

   // read-modify-write of one cell
   always_comb begin
      wr_data              = row_rd;
      wr_data[item_col_ff] = item_open_ff;
   end

   // neighbor rows
   always_ff @(posedge clock) begin
      if (cmd.cap_up) begin
         row_up_ff <= row_rd;
      end
      if (cmd.cap_mid) begin
         row_mid_ff <= row_rd;
      end
      if (cmd.cap_dn) begin
         row_dn_ff <= row_rd;
      end
   end

   // open neighbors, out-of-grid counts as wall
   assign col_p1 = cur_col_ff + 1'b1;
   assign col_m1 = cur_col_ff - 1'b1;

   always_comb begin
      dir_open[DIR_DOWN]  = (cur_row_ff != LAST_ROW) ? row_dn_ff[cur_col_ff] : 1'b0;
      dir_open[DIR_RIGHT] = (cur_col_ff != LAST_COL) ? row_mid_ff[col_p1] : 1'b0;
      dir_open[DIR_UP]    = (cur_row_ff != '0) ? row_up_ff[cur_col_ff] : 1'b0;
      dir_open[DIR_LEFT]  = (cur_col_ff != '0) ? row_mid_ff[col_m1] : 1'b0;
   end

   // first open direction, starting at the heading
   always_comb begin
      dir_type dir;
      found  = 1'b0;
      mv_dir = DIR_DOWN;
      for (int k = 0; k < 4; k++) begin
         dir = dir_type'(2'(int'(heading_ff) + k));
         if (!found && dir_open[dir]) begin
            found  = 1'b1;
            mv_dir = dir;
         end
      end
   end

   // target cell and its outcome
   always_comb begin
      nxt_row = cur_row_ff;
      nxt_col = cur_col_ff;
      case (mv_dir)
         DIR_DOWN:  nxt_row = cur_row_ff + 1'b1;
         DIR_RIGHT: nxt_col = col_p1;
         DIR_UP:    nxt_row = cur_row_ff - 1'b1;
         DIR_LEFT:  nxt_col = col_m1;
         default: ;
      endcase
      at_start = (nxt_row == start_r) && (nxt_col == start_c);
      at_edge  = (nxt_row == '0) || (nxt_row == LAST_ROW) ||
                 (nxt_col == '0) || (nxt_col == LAST_COL);
      if (at_edge && !at_start) begin
         mv_outcome = OUT_EXITED;
      end else if (at_start) begin
         mv_outcome = OUT_BACK;
      end else begin
         mv_outcome = OUT_MOVING;
      end
   end

   // walker state
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_row_ff  <= '0;
         cur_col_ff  <= '0;
         heading_ff  <= DIR_RIGHT;
         finished_ff <= 1'b1;
         outcome_ff  <= OUT_MOVING;
      end else if (cmd.restart) begin
         cur_row_ff  <= start_r;
         cur_col_ff  <= start_c;
         heading_ff  <= DIR_RIGHT;
         finished_ff <= 1'b0;
         outcome_ff  <= OUT_MOVING;
      end else if (cmd.move) begin
         if (found) begin
            cur_row_ff  <= nxt_row;
            cur_col_ff  <= nxt_col;
            heading_ff  <= turn_after(mv_dir);
            outcome_ff  <= mv_outcome;
            finished_ff <= (mv_outcome != OUT_MOVING);
         end else begin
            outcome_ff  <= OUT_STUCK;
            finished_ff <= 1'b1;
         end
      end
   end

   // response register, position in the low bits of the fields
   assign cur_row_x = RXW'(cur_row_ff);
   assign cur_col_x = CXW'(cur_col_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_pos_row_ff <= cur_row_x[ROW_W-1:0];
         rsp_pos_col_ff <= cur_col_x[COL_W-1:0];
         rsp_outcome_ff <= outcome_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pos_row = rsp_pos_row_ff;
   assign rsp_pos_col = rsp_pos_col_ff;
   assign rsp_outcome = rsp_outcome_ff;

   // walker never leaves the grid
   a_pos_in_grid: assert property (@(posedge clock) disable iff (reset)
      (int'(cur_row_ff) < GRID_ROWS) && (int'(cur_col_ff) < GRID_COLS))
      else $error("walker position outside the grid");

   // an active walk always reports moving
   a_active_moving: assert property (@(posedge clock) disable iff (reset)
      !finished_ff |-> (outcome_ff == OUT_MOVING))
      else $error("active walk with a final outcome");

   // restart lands on the saturated start cell
   a_restart_start: assert property (@(posedge clock) disable iff (reset)
      cmd.restart |=> (cur_row_ff == $past(start_r)) && (cur_col_ff == $past(start_c)))
      else $error("restart did not place walker at start");

   // response slot is never overwritten
   a_rsp_no_overrun: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("response overwritten before taken");

endmodule

>>> rtl/core/grid_wall_follower.sv
// ----------------------------------------------------------------------------
// grid_wall_follower: right-hand wall follower over a loadable grid maze
// Top level: sequencer, datapath with map memory, register write port.
// ----------------------------------------------------------------------------
// The block keeps a GRID_ROWS x GRID_COLS wall/open map, one memory row per
// grid row. A write request (op 0) reads the row and writes it back with one
// cell changed; writes outside the grid are dropped. A step request (op 1)
// reads the rows above, at and below the walker one per cycle through the map
// memory's single read port, resolves the move and registers the response.
// A restart (op 2) places the walker on the start cell, and a step on a
// finished walk registers the response without a move. Requests are handled
// one at a time; a response waits in its output register while the next
// request is accepted. The map reads as all walls after reset through per-row
// valid bits, so there is no clearing pass. Register writes are always taken
// and must only happen while idle.
module grid_wall_follower import gwf_pkg::*; #(
   parameter int GRID_ROWS = DEF_GRID_ROWS,
   parameter int GRID_COLS = DEF_GRID_COLS
) (
   input  logic      clock,
   input  logic      reset,
   gwf_req_if.sink   req_bus,
   gwf_rsp_if.source rsp_bus,
   gwf_csr_if.sink   csr_bus
);

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   // register writes are always taken
   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = req_ready;

   gwf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gwf_dp #(
      .GRID_ROWS (GRID_ROWS),
      .GRID_COLS (GRID_COLS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_op        (req_bus.op),
      .req_cell_row  (req_bus.cell_row),
      .req_cell_col  (req_bus.cell_col),
      .req_cell_open (req_bus.cell_open),
      .csr_write     (csr_bus.valid),
      .csr_index     (csr_bus.index),
      .csr_data      (csr_bus.data),
      .rsp_valid     (rsp_bus.valid),
      .rsp_ready     (rsp_bus.ready),
      .rsp_pos_row   (rsp_bus.pos_row),
      .rsp_pos_col   (rsp_bus.pos_col),
      .rsp_outcome   (rsp_bus.outcome)
   );

endmodule

>>> bench/gwf_walk_checker.sv
// ----------------------------------------------------------------------------
// gwf_walk_checker: response checker for the grid wall follower
// Watches the request, response and register channels. Keeps its own copy of
// the maze map, the walker and the start registers, predicts the response of
// every accepted restart or step, and compares responses field by field.
// ----------------------------------------------------------------------------
module gwf_walk_checker import gwf_pkg::*; (
   input  logic clock,
   input  logic reset,
   gwf_req_if   req_mon,
   gwf_rsp_if   rsp_mon,
   gwf_csr_if   csr_mon,
   output int   error_count,
   output int   expect_pending,
   output int   checked_count,
   output int   exited_count,
   output int   back_count,
   output int   stuck_count
);

   localparam int GRID_ROWS = DEF_GRID_ROWS;
   localparam int GRID_COLS = DEF_GRID_COLS;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      outcome_type      outcome;
   } walker_report_type;

   // predicted responses, oldest first
   walker_report_type expected_reports[$];

   // shadow of the maze and the walker
   logic [GRID_COLS-1:0] open_map [GRID_ROWS];
   int                   walker_row;
   int                   walker_col;
   dir_type              heading;
   logic                 walk_done;
   outcome_type          last_outcome;
   logic [ROW_W-1:0]     entry_row;
   logic [COL_W-1:0]     entry_col;

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("[%0t] gwf_walk_checker: %s", $time, msg);
   endtask

   // start coordinates clamp to the last row/column of the grid
   function automatic int entry_row_eff();
      return (int'(entry_row) < GRID_ROWS) ? int'(entry_row) : GRID_ROWS - 1;
   endfunction

   function automatic int entry_col_eff();
      return (int'(entry_col) < GRID_COLS) ? int'(entry_col) : GRID_COLS - 1;
   endfunction

   function automatic bit is_open(input int r, input int c);
      if (r < 0 || r >= GRID_ROWS || c < 0 || c >= GRID_COLS) begin
         return 1'b0;
      end
      return open_map[r][c];
   endfunction

   // one move: first open neighbor in order down, right, up, left from heading
   task automatic take_step();
      dir_type d;
      int      nr;
      int      nc;
      bit      moved;
      bit      home;
      bit      on_edge;
      moved = 1'b0;
      for (int i = 0; i < 4 && !moved; i++) begin
         d  = dir_type'(heading + 2'(i));
         nr = walker_row;
         nc = walker_col;
         case (d)
            DIR_DOWN:  nr = walker_row + 1;
            DIR_RIGHT: nc = walker_col + 1;
            DIR_UP:    nr = walker_row - 1;
            default:   nc = walker_col - 1;
         endcase
         if (is_open(nr, nc)) begin
            moved      = 1'b1;
            walker_row = nr;
            walker_col = nc;
            // turn table: the wall stays on the walker's hand side
            case (d)
               DIR_DOWN:  heading = DIR_LEFT;
               DIR_RIGHT: heading = DIR_DOWN;
               DIR_UP:    heading = DIR_RIGHT;
               default:   heading = DIR_UP;
            endcase
            home    = (nr == entry_row_eff()) && (nc == entry_col_eff());
            on_edge = (nr == 0) || (nr == GRID_ROWS - 1) || (nc == 0) || (nc == GRID_COLS - 1);
            if (on_edge && !home) begin
               last_outcome = OUT_EXITED;
               walk_done    = 1'b1;
               exited_count++;
            end else if (home) begin
               last_outcome = OUT_BACK;
               walk_done    = 1'b1;
               back_count++;
            end else begin
               last_outcome = OUT_MOVING;
            end
         end
      end
      if (!moved) begin
         last_outcome = OUT_STUCK;
         walk_done    = 1'b1;
         stuck_count++;
      end
   endtask

   task automatic predict_request(input op_type op, input logic [ROW_W-1:0] row,
                                  input logic [COL_W-1:0] col, input logic open_bit);
      walker_report_type rep;
      case (op)
         OP_WRITE: begin
            if (int'(row) < GRID_ROWS && int'(col) < GRID_COLS) begin
               open_map[row][col] = open_bit;
            end
         end
         OP_RESTART, OP_STEP: begin
            if (op == OP_RESTART) begin
               walker_row   = entry_row_eff();
               walker_col   = entry_col_eff();
               heading      = DIR_RIGHT;
               walk_done    = 1'b0;
               last_outcome = OUT_MOVING;
            end else if (!walk_done) begin
               take_step();
            end
            rep.row     = ROW_W'(walker_row);
            rep.col     = COL_W'(walker_col);
            rep.outcome = last_outcome;
            expected_reports.push_back(rep);
         end
         default: ;
      endcase
   endtask

   // all channel beats are taken at the rising edge
   always @(posedge clock) begin : track
      walker_report_type seen;
      walker_report_type want;
      if (reset) begin
         for (int r = 0; r < GRID_ROWS; r++) begin
            open_map[r] = '0;
         end
         walker_row   = 0;
         walker_col   = 0;
         heading      = DIR_RIGHT;
         walk_done    = 1'b1;
         last_outcome = OUT_MOVING;
         entry_row    = '0;
         entry_col    = '0;
         expected_reports.delete();
      end else begin
         // response first: a request in this same beat cannot be its source
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.row     = rsp_mon.pos_row;
            seen.col     = rsp_mon.pos_col;
            seen.outcome = rsp_mon.outcome;
            if (expected_reports.size() == 0) begin
               report_mismatch($sformatf("response (%0d,%0d) outcome %0d with none expected",
                                         seen.row, seen.col, seen.outcome));
            end else begin
               want = expected_reports.pop_front();
               checked_count++;
               if (seen.row !== want.row) begin
                  report_mismatch($sformatf("pos_row got %0d expected %0d", seen.row, want.row));
               end
               if (seen.col !== want.col) begin
                  report_mismatch($sformatf("pos_col got %0d expected %0d", seen.col, want.col));
               end
               if (seen.outcome !== want.outcome) begin
                  report_mismatch($sformatf("outcome got %0d expected %0d at (%0d,%0d)",
                                            seen.outcome, want.outcome, want.row, want.col));
               end
            end
         end
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_START_ROW: entry_row = csr_mon.data[ROW_W-1:0];
               CSR_START_COL: entry_col = csr_mon.data[COL_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            predict_request(req_mon.op, req_mon.cell_row, req_mon.cell_col, req_mon.cell_open);
         end
      end
      expect_pending = expected_reports.size();
   end

   initial begin
      error_count    = 0;
      expect_pending = 0;
      checked_count  = 0;
      exited_count   = 0;
      back_count     = 0;
      stuck_count    = 0;
   end

endmodule

>>> bench/tb_grid_wall_follower.sv
// ----------------------------------------------------------------------------
// tb_grid_wall_follower: testbench top of the grid wall follower
// Resets the block, runs a short directed walk set (stuck, exit, back at
// start, sticky outcomes, steps before any restart), then carves random
// corridors from a series of start cells and walks them, with map edits and
// restarts in mid-walk. Bursty requests and a stalling receiver; responses
// are checked by gwf_walk_checker.
// ----------------------------------------------------------------------------
module tb_grid_wall_follower;
   import gwf_pkg::*;

   localparam int ITEM_TARGET   = 1750;
   localparam int HOLD_CYCLES   = 12;
   localparam int DRAIN_CYCLES  = 20;
   localparam int STALL_LIMIT   = 2000;
   localparam int LAST_ROW      = DEF_GRID_ROWS - 1;
   localparam int LAST_COL      = DEF_GRID_COLS - 1;

   logic clock;
   logic reset;

   gwf_req_if req_bus ();
   gwf_rsp_if rsp_bus ();
   gwf_csr_if csr_bus ();

   int error_count;
   int expect_pending;
   int checked_count;
   int exited_count;
   int back_count;
   int stuck_count;

   int items_sent;
   int burst_left;
   int start_settings;
   bit sender_calm;

   grid_wall_follower i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   gwf_walk_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_mon        (csr_bus),
      .error_count    (error_count),
      .expect_pending (expect_pending),
      .checked_count  (checked_count),
      .exited_count   (exited_count),
      .back_count     (back_count),
      .stuck_count    (stuck_count)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // one request beat; bursts of random length with random gaps between
   task automatic send_request(input op_type op, input logic [ROW_W-1:0] row,
                               input logic [COL_W-1:0] col, input logic open_bit);
      int gap;
      if (burst_left == 0) begin
         gap = (sender_calm || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_bus.valid     <= 1'b1;
      req_bus.op        <= op;
      req_bus.cell_row  <= row;
      req_bus.cell_col  <= col;
      req_bus.cell_open <= open_bit;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      burst_left--;
      if (op != OP_NOP) begin
         items_sent++;
      end
   endtask

   // non-write ops carry random payload in the unused fields
   task automatic send_op(input op_type op);
      send_request(op, ROW_W'($urandom), COL_W'($urandom), 1'($urandom));
   endtask

   task automatic write_cell(input int r, input int c, input bit open_bit);
      send_request(OP_WRITE, ROW_W'(r), COL_W'(c), open_bit);
   endtask

   // stop sending and let every response and any map write finish
   task automatic hold_until_drained();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (expect_pending != 0);
      repeat (HOLD_CYCLES) @(negedge clock);
      burst_left = 0;
   endtask

   task automatic csr_beat(input csr_idx_type idx, input logic [CSR_D_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
   endtask

   // both start registers, in random order; only called while idle
   task automatic configure_start(input logic [CSR_D_W-1:0] row_data,
                                  input logic [CSR_D_W-1:0] col_data);
      if ($urandom_range(0, 1) == 0) begin
         csr_beat(CSR_START_ROW, row_data);
         csr_beat(CSR_START_COL, col_data);
      end else begin
         csr_beat(CSR_START_COL, col_data);
         csr_beat(CSR_START_ROW, row_data);
      end
      csr_bus.valid <= 1'b0;
      start_settings++;
   endtask

   // carve a random corridor from a start cell, then walk it
   task automatic run_maze_phase();
      int sr;
      int sc;
      int r;
      int c;
      int len;
      int pick;
      pick = $urandom_range(0, 5);
      case (pick)
         0:       begin sr = 0;        sc = 0;        end
         1:       begin sr = LAST_ROW; sc = LAST_COL; end
         2:       begin sr = 0;        sc = LAST_COL; end
         3:       begin sr = LAST_ROW; sc = 0;        end
         default: begin
            sr = $urandom_range(0, LAST_ROW);
            sc = $urandom_range(0, LAST_COL);
         end
      endcase
      hold_until_drained();
      // row register ignores data bit 4
      configure_start({1'($urandom), ROW_W'(sr)}, COL_W'(sc));
      sender_calm = ($urandom_range(0, 4) == 0);

      // start cell is open most of the time, sometimes a wall
      write_cell(sr, sc, $urandom_range(0, 4) != 0);
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(3, 25);
      r = sr;
      c = sc;
      repeat (len) begin
         case ($urandom_range(0, 3))
            0:       if (r < LAST_ROW) r++;
            1:       if (c < LAST_COL) c++;
            2:       if (r > 0) r--;
            default: if (c > 0) c--;
         endcase
         if ($urandom_range(0, 15) == 0) begin
            send_op(OP_NOP);
         end
         write_cell(r, c, 1'b1);
      end
      // scattered walls keep the map from filling up
      repeat ($urandom_range(0, len / 3 + 1)) begin
         write_cell($urandom_range(0, LAST_ROW), $urandom_range(0, LAST_COL), 1'b0);
      end

      send_op(OP_RESTART);
      repeat ($urandom_range(len / 2 + 1, len + 8)) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            write_cell($urandom_range(0, LAST_ROW), $urandom_range(0, LAST_COL),
                       1'($urandom));
         end else if (pick == 1) begin
            send_op(OP_RESTART);
         end else if (pick == 2) begin
            send_op(OP_NOP);
         end
         send_op(OP_STEP);
      end
   endtask

   // receiver: stall pattern switches between none, light and heavy
   initial begin : rsp_stall_pattern
      int stall_left;
      int mode_left;
      int mode;
      rsp_bus.ready = 1'b0;
      stall_left = 0;
      mode_left  = 0;
      mode       = 0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 2);
            mode_left = $urandom_range(50, 300);
         end
         mode_left--;
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else if (mode != 0 && $urandom_range(0, (mode == 1) ? 7 : 2) == 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left = $urandom_range(0, 7);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // watchdog: too many cycles without any beat on any channel
   initial begin : watchdog
      int stalled;
      stalled = 0;
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
             || (csr_bus.valid && csr_bus.ready)) begin
            stalled = 0;
         end else begin
            stalled++;
         end
      end
      $display("timeout: no channel activity for %0d cycles", STALL_LIMIT);
      $display("tb_grid_wall_follower: errors");
      $finish;
   end

   initial begin : stimulus
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.op        = OP_WRITE;
      req_bus.cell_row  = '0;
      req_bus.cell_col  = '0;
      req_bus.cell_open = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = CSR_START_ROW;
      csr_bus.data      = '0;
      items_sent        = 0;
      burst_left        = 0;
      start_settings    = 0;
      sender_calm       = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // idle walk after reset, unused op, stuck at a walled-in start
      send_op(OP_STEP);
      send_op(OP_NOP);
      send_op(OP_RESTART);
      send_op(OP_STEP);
      send_op(OP_STEP);
      // corner cells; walker leaves through the top edge
      write_cell(0, 1, 1'b1);
      write_cell(LAST_ROW, LAST_COL, 1'b1);
      write_cell(LAST_ROW, 0, 1'b1);
      write_cell(0, LAST_COL, 1'b0);
      send_op(OP_RESTART);
      send_op(OP_STEP);
      send_op(OP_STEP);

      // far corner start, no way out
      hold_until_drained();
      configure_start(5'h1F, COL_W'(LAST_COL));
      send_op(OP_RESTART);
      send_op(OP_STEP);

      // small loop that returns to the start
      hold_until_drained();
      configure_start(5'd5, 5'd5);
      write_cell(5, 6, 1'b1);
      write_cell(6, 6, 1'b1);
      write_cell(6, 5, 1'b1);
      write_cell(5, 5, 1'b1);
      send_op(OP_RESTART);
      repeat (5) send_op(OP_STEP);

      while (items_sent < ITEM_TARGET) begin
         run_maze_phase();
      end

      req_bus.valid <= 1'b0;
      do @(negedge clock); while (expect_pending != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d request beats over %0d start settings, %0d responses checked",
               items_sent, start_settings, checked_count);
      $display("walks ended: %0d exited, %0d back at start, %0d stuck",
               exited_count, back_count, stuck_count);
      if (error_count == 0) begin
         $display("tb_grid_wall_follower: clean");
      end else begin
         $display("tb_grid_wall_follower: errors");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/gwf_pkg.sv
rtl/core/gwf_if.sv
rtl/core/gwf_ram.sv
rtl/core/gwf_ctrl.sv
rtl/core/gwf_dp.sv
rtl/core/grid_wall_follower.sv
bench/gwf_walk_checker.sv
bench/tb_grid_wall_follower.sv
